// ===== rtl/mrf_pkg.sv =====
// Shared constants, types and the address hash for the MAC receive filter.
`default_nettype none
package mrf_pkg;

  localparam int unsigned AddrWidth   = 48;
  localparam int unsigned FilterWidth = 64;
  localparam int unsigned HashWidth   = 6;
  localparam int unsigned ModeWidth   = 6;
  localparam int unsigned CfgIdxWidth = 8;
  localparam int unsigned CfgDatWidth = 64;

  // Register indexes on the configuration port
  localparam logic [CfgIdxWidth-1:0] RegModeFlags = 8'd0;
  localparam logic [CfgIdxWidth-1:0] RegStation   = 8'd1;
  localparam logic [CfgIdxWidth-1:0] RegUniHash   = 8'd2;
  localparam logic [CfgIdxWidth-1:0] RegMultiHash = 8'd3;

  // Mode flag bit positions
  localparam int unsigned FlagPromisc  = 0;
  localparam int unsigned FlagAllMulti = 1;
  localparam int unsigned FlagAllUni   = 2;
  localparam int unsigned FlagNoMulti  = 3;
  localparam int unsigned FlagNoUni    = 4;
  localparam int unsigned FlagNoBcast  = 5;

  localparam logic [AddrWidth-1:0] BcastAddr = 48'hFFFF_FFFF_FFFF;
  localparam int unsigned GroupBit = 40;

  typedef logic [AddrWidth-1:0] mac_addr_t;
  typedef logic [HashWidth-1:0] hash_t;

  typedef struct packed {
    logic [ModeWidth-1:0]   mode_flags;
    mac_addr_t              station_address;
    logic [FilterWidth-1:0] unicast_hash_filter;
    logic [FilterWidth-1:0] multicast_hash_filter;
  } mrf_cfg_t;

  // Contribution of three consecutive bytes to the 6-bit fold
  function automatic hash_t fold_triplet(input logic [7:0] a, input logic [7:0] b,
                                         input logic [7:0] c);
    hash_t h;
    h = a[5:0] ^ {4'b0, a[7:6]} ^ {b[3:0], 2'b0} ^ {2'b0, b[7:4]}
        ^ {c[1:0], 4'b0} ^ c[7:2];
    return h;
  endfunction

  function automatic hash_t fold_hash(input mac_addr_t a);
    hash_t h;
    h = fold_triplet(a[47:40], a[39:32], a[31:24])
        ^ fold_triplet(a[23:16], a[15:8], a[7:0]);
    return h;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/mrf_decide.sv =====
// Accept/drop decision for one destination address against the filter setup.
`default_nettype none
module mrf_decide (
  input  mrf_pkg::mac_addr_t dest_address_i,
  input  mrf_pkg::mrf_cfg_t  cfg_i,
  output logic               accept_o
);
  import mrf_pkg::*;

  hash_t h;
  logic  uni_hit;
  logic  multi_hit;
  logic  is_group;

  assign h         = fold_hash(dest_address_i);
  assign uni_hit   = cfg_i.unicast_hash_filter[h];
  assign multi_hit = cfg_i.multicast_hash_filter[h];
  assign is_group  = dest_address_i[GroupBit];

  always_comb begin
    if (cfg_i.mode_flags[FlagPromisc]) begin
      accept_o = 1'b1;
    end else if (!is_group) begin
      // no-unicast wins over all-unicast
      if (cfg_i.mode_flags[FlagNoUni] || cfg_i.mode_flags[FlagAllUni]) begin
        accept_o = !cfg_i.mode_flags[FlagNoUni];
      end else if (dest_address_i == cfg_i.station_address) begin
        accept_o = 1'b1;
      end else begin
        accept_o = uni_hit;
      end
    end else if (dest_address_i == BcastAddr) begin
      accept_o = !cfg_i.mode_flags[FlagNoBcast];
    end else if (cfg_i.mode_flags[FlagNoMulti] || cfg_i.mode_flags[FlagAllMulti]) begin
      accept_o = !cfg_i.mode_flags[FlagNoMulti];
    end else begin
      accept_o = multi_hit;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/mac_receive_filter_unit.sv =====
// Each input transfer is captured in the input register, which feeds the result register.
// Throughput: one address per cycle while the output is not stalled; the hash and compare sit between the regs.
// A stalled result keeps one more address parked in the input register.
// Reset: asynchronous, active low; clears valids and all filter registers
// (mode, station address, both hash filters read as zero).
`default_nettype none
module mac_receive_filter_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [mrf_pkg::CfgIdxWidth-1:0] cfg_index_i,
  input  logic [mrf_pkg::CfgDatWidth-1:0] cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  mrf_pkg::mac_addr_t          dest_address_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        accept_o
);
  import mrf_pkg::*;

  mrf_cfg_t  cfg_q;
  logic      in_valid_q;
  mac_addr_t addr_q;
  logic      out_valid_q;
  logic      accept_q;
  logic      accept_d;
  logic      out_adv;
  logic      in_xfer;

  // Filter registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegModeFlags: cfg_q.mode_flags            <= cfg_data_i[ModeWidth-1:0];
        RegStation:   cfg_q.station_address       <= cfg_data_i[AddrWidth-1:0];
        RegUniHash:   cfg_q.unicast_hash_filter   <= cfg_data_i;
        RegMultiHash: cfg_q.multicast_hash_filter <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign out_adv    = !out_valid_q || !out_stall_i;
  assign in_stall_o = in_valid_q && !out_adv;
  assign in_xfer    = in_valid_i && !in_stall_o;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      addr_q <= dest_address_i;
    end
  end

  mrf_decide u_decide (
    .dest_address_i (addr_q),
    .cfg_i          (cfg_q),
    .accept_o       (accept_d)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_adv) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_adv && in_valid_q) begin
      accept_q <= accept_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign accept_o    = accept_q;

endmodule
`default_nettype wire

// ===== rtl/mrf_checker.sv =====
// Port-level checks for the MAC receive filter and their bind to the top level.
`default_nettype none
module mrf_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input logic accept_o
);

  // A stalled result stays and holds its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(accept_o)))
    else $error("result changed while stalled");

  // Input side only backs up when the output side is stalled
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |-> !in_stall_o)
    else $error("input stalled with output free");

  // Transfer in, then a free output cycle, gives a result next cycle
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) ##1 !out_stall_i |=> out_valid_o)
    else $error("result missing after transfer");

  // Both slots full under a held stall: input must back up
  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i && in_valid_i && !in_stall_o)
      |=> (out_stall_i |-> in_stall_o))
    else $error("pipeline overrun under stall");

endmodule

bind mac_receive_filter_unit mrf_checker u_mrf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .accept_o    (accept_o)
);
`default_nettype wire

// ===== verif/tb_mac_receive_filter_unit.sv =====
// Self-checking testbench for mac_receive_filter_unit: directed and random frames against a model.
`default_nettype none
module tb_mac_receive_filter_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import mrf_pkg::*;

  localparam logic [ModeWidth-1:0] ModePromisc  = ModeWidth'(1 << FlagPromisc);
  localparam logic [ModeWidth-1:0] ModeAllMulti = ModeWidth'(1 << FlagAllMulti);
  localparam logic [ModeWidth-1:0] ModeAllUni   = ModeWidth'(1 << FlagAllUni);
  localparam logic [ModeWidth-1:0] ModeNoMulti  = ModeWidth'(1 << FlagNoMulti);
  localparam logic [ModeWidth-1:0] ModeNoUni    = ModeWidth'(1 << FlagNoUni);
  localparam logic [ModeWidth-1:0] ModeNoBcast  = ModeWidth'(1 << FlagNoBcast);
  localparam logic [ModeWidth-1:0] ModeAll      = '1;
  localparam int unsigned HoldCycles = 80;

  typedef struct packed {
    mac_addr_t addr;
    logic      accept;
  } frame_verdict_t;

  logic                   clk_i          = 1'b0;
  logic                   rst_ni         = 1'b0;
  logic                   cfg_we_i       = 1'b0;
  logic [CfgIdxWidth-1:0] cfg_index_i    = '0;
  logic [CfgDatWidth-1:0] cfg_data_i     = '0;
  logic                   in_valid_i     = 1'b0;
  logic                   in_stall_o;
  mac_addr_t              dest_address_i = '0;
  logic                   out_valid_o;
  logic                   out_stall_i    = 1'b0;
  logic                   accept_o;

  mac_receive_filter_unit uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .dest_address_i (dest_address_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .accept_o       (accept_o)
  );

  // Filter settings as the block should hold them
  logic [ModeWidth-1:0]   cfg_mode    = '0;
  mac_addr_t              cfg_station = '0;
  logic [FilterWidth-1:0] cfg_uni     = '0;
  logic [FilterWidth-1:0] cfg_multi   = '0;

  frame_verdict_t verdict_q[$];
  frame_verdict_t chk_verdict;
  int unsigned    errors         = 0;
  int unsigned    frames_sent    = 0;
  int unsigned    results_seen   = 0;
  int unsigned    accepts_seen   = 0;
  int unsigned    settings_used  = 0;
  bit             gaps_on        = 1'b0;
  logic           stall_en       = 1'b0;
  logic           hold_go        = 1'b0;
  logic           hold_armed     = 1'b0;
  int unsigned    hold_left      = 0;

  always #2 clk_i = ~clk_i;

  function automatic hash_t addr_hash(input mac_addr_t a);
    logic [31:0] b [6];
    logic [31:0] h;
    for (int k = 0; k < 6; k++) b[k] = 32'(a[47-8*k -: 8]);
    h = b[0] ^ (b[0] >> 6) ^ (b[1] << 2) ^ (b[1] >> 4) ^ (b[2] << 4) ^ (b[2] >> 2)
        ^ b[3] ^ (b[3] >> 6) ^ (b[4] << 2) ^ (b[4] >> 4) ^ (b[5] << 4) ^ (b[5] >> 2);
    return h[HashWidth-1:0];
  endfunction

  function automatic logic predict_accept(input mac_addr_t a);
    if (cfg_mode[FlagPromisc]) return 1'b1;
    if (!a[GroupBit]) begin
      // no-unicast beats all-unicast
      if (cfg_mode[FlagNoUni]) return 1'b0;
      if (cfg_mode[FlagAllUni]) return 1'b1;
      if (a == cfg_station) return 1'b1;
      return cfg_uni[addr_hash(a)];
    end
    if (a == BcastAddr) return !cfg_mode[FlagNoBcast];
    if (cfg_mode[FlagNoMulti]) return 1'b0;
    if (cfg_mode[FlagAllMulti]) return 1'b1;
    return cfg_multi[addr_hash(a)];
  endfunction

  function automatic mac_addr_t pick_address();
    int unsigned sel;
    mac_addr_t   a;
    sel = $urandom_range(99);
    a = {16'($urandom), 32'($urandom)};
    if (sel < 15) a = cfg_station;
    else if (sel < 23) a = BcastAddr;
    else if (sel < 35) a = cfg_station ^ (48'd1 << $urandom_range(AddrWidth - 1));
    return a;
  endfunction

  function automatic logic [FilterWidth-1:0] pick_filter();
    int unsigned sel;
    sel = $urandom_range(9);
    if (sel == 0) return '0;
    if (sel == 1) return '1;
    if (sel == 2) return 64'd1 << $urandom_range(FilterWidth - 1);
    return {$urandom, $urandom};
  endfunction

  // Receiver: random stalls, or one long hold-off counted here
  always @(posedge clk_i) begin
    if (hold_go && !hold_armed) begin
      hold_armed  <= 1'b1;
      hold_left   <= HoldCycles;
      out_stall_i <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (stall_en) begin
      out_stall_i <= ($urandom_range(99) < 37);
    end else begin
      out_stall_i <= 1'b0;
    end
    if (!hold_go) hold_armed <= 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (verdict_q.size() == 0) begin
        errors++;
        $display("%0t: accept %0b arrived with no frame outstanding", $time, accept_o);
      end else begin
        chk_verdict = verdict_q.pop_front();
        results_seen++;
        if (accept_o === 1'b1) accepts_seen++;
        if (accept_o !== chk_verdict.accept) begin
          errors++;
          $display("%0t: accept for %012h: expected %0b, actual %0b", $time,
                   chk_verdict.addr, chk_verdict.accept, accept_o);
        end
      end
    end
  end

  // Leaves valid high on return; the caller sends again or settles in the same step
  task automatic send_frame(input mac_addr_t a);
    frame_verdict_t v;
    if (gaps_on && $urandom_range(99) < 37) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    dest_address_i <= a;
    do @(posedge clk_i); while (in_stall_o);
    v.addr   = a;
    v.accept = predict_accept(a);
    verdict_q.push_back(v);
    frames_sent++;
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Leaves the write enable high; end_writes drops it
  task automatic write_reg(input logic [CfgIdxWidth-1:0] idx, input logic [CfgDatWidth-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    case (idx)
      RegModeFlags: cfg_mode    = data[ModeWidth-1:0];
      RegStation:   cfg_station = data[AddrWidth-1:0];
      RegUniHash:   cfg_uni     = data;
      RegMultiHash: cfg_multi   = data;
      default: ;
    endcase
  endtask

  task automatic end_writes();
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  task automatic test_reset_defaults();
    // all registers zero: address zero matches the station, hash filters reject
    send_frame('0);
    send_frame(BcastAddr);
    send_frame(48'h0100_0000_0000);
    send_frame(48'hFEFF_FFFF_FFFF);
    settle();
  endtask

  task automatic test_register_edges();
    // junk above the mode and station register widths, and writes to unused indexes
    write_reg(RegModeFlags, 64'hFFFF_FFFF_FFFF_FFC0);
    write_reg(RegStation, 64'hFFFF_0200_0000_0001);
    write_reg(RegUniHash, '1);
    write_reg(RegMultiHash, '0);
    write_reg(CfgIdxWidth'(4), '1);
    write_reg('1, '1);
    end_writes();
    send_frame(48'h0200_0000_0001);
    send_frame(48'hFEFF_FFFF_FFFF);
    send_frame(48'h0100_0000_0000);
    send_frame(BcastAddr);
    settle();
  endtask

  task automatic test_mode_flags();
    logic [ModeWidth-1:0] modes [8];
    mac_addr_t            a;
    modes = '{ModePromisc, ModeAllMulti, ModeAllUni, ModeNoMulti, ModeNoUni, ModeNoBcast,
              ModeNoUni | ModeAllUni, ModeNoMulti | ModeAllMulti};
    foreach (modes[i]) begin
      write_reg(RegModeFlags, CfgDatWidth'(modes[i]));
      write_reg(RegStation, {16'h0, 16'($urandom), 32'($urandom)});
      write_reg(RegUniHash, '0);
      write_reg(RegMultiHash, '0);
      end_writes();
      a = {16'($urandom), 32'($urandom)};
      a[GroupBit] = 1'b0;
      send_frame(a);
      a[GroupBit] = 1'b1;
      a[0] = 1'b0;
      send_frame(a);
      send_frame(BcastAddr);
      settle();
    end
  endtask

  task automatic test_output_holdoff();
    gaps_on = 1'b0;
    stall_en <= 1'b0;
    hold_go  <= 1'b1;
    for (int n = 0; n < 20; n++) send_frame(pick_address());
    // sender waits here until every outstanding result is in
    settle();
    hold_go <= 1'b0;
  endtask

  task automatic test_random_phases();
    int unsigned          sel;
    logic [ModeWidth-1:0] m;
    mac_addr_t            st;
    for (int p = 0; p < 13; p++) begin
      sel = $urandom_range(99);
      m = ModeWidth'($urandom_range(63));
      if (sel < 25) m = '0;
      else if (sel < 32) m = ModeAll;
      else if (sel < 70) m[FlagPromisc] = 1'b0;
      sel = $urandom_range(9);
      st = {16'($urandom), 32'($urandom)};
      if (sel == 0) st = '0;
      else if (sel == 1) st = '1;
      else if (sel < 6) st[GroupBit] = 1'b0;
      write_reg(RegModeFlags, {32'($urandom), 26'($urandom), m});
      write_reg(RegStation, {16'($urandom), st});
      write_reg(RegUniHash, pick_filter());
      write_reg(RegMultiHash, pick_filter());
      end_writes();
      // one phase runs with no idling on either side
      gaps_on = (p != 5);
      stall_en <= (p != 5);
      for (int n = 0; n < 50; n++) send_frame(pick_address());
      settle();
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    gaps_on = 1'b1;
    stall_en <= 1'b1;
    test_reset_defaults();
    test_register_edges();
    test_mode_flags();
    test_output_holdoff();
    test_random_phases();
    settle();
    $display("%0d frames sent, %0d verdicts checked (%0d accepted) over %0d filter settings",
             frames_sent, results_seen, accepts_seen, settings_used);
    $display("covered single and conflicting mode flags, station match, both hash filters");
    if (errors == 0) begin
      $display("tb_mac_receive_filter_unit: done, clean");
    end else begin
      $display("tb_mac_receive_filter_unit: done, errors");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d results outstanding", verdict_q.size());
    $display("tb_mac_receive_filter_unit: done, errors");
    $finish;
  end

endmodule
`default_nettype wire
